### hdl/xsr_pkg.sv
// Shared types, constants and helpers for the xor/shift/rotate generator.
package xsr_pkg;

	localparam int WORD_W    = 64;
	localparam int NUM_WORDS = 8;
	localparam int IDX_W     = $clog2(NUM_WORDS);
	localparam int VAR_W     = 3;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [NUM_WORDS-1:0][WORD_W-1:0] state_t;
	typedef logic [1:0] scr_t;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_GEN  = 1'b1;

	localparam logic [VAR_W-1:0] VAR_RST       = 3'd2;
	localparam logic [VAR_W-1:0] VAR_MAX       = 3'd5;
	localparam logic [VAR_W-1:0] VAR_WIDE_BASE = 3'd3;

	localparam scr_t SCR_PLUS = 2'd0;
	localparam scr_t SCR_PP   = 2'd1;
	localparam scr_t SCR_SS   = 2'd2;

	localparam int SHL256 = 17;
	localparam int ROT256 = 45;
	localparam int PP256  = 23;
	localparam int SHL512 = 11;
	localparam int ROT512 = 21;
	localparam int PP512  = 17;
	localparam int SS_ROT = 7;

	function automatic word_t rotl(input word_t x, input int k);
		return (x << k) | (x >> (WORD_W - k));
	endfunction

endpackage

### hdl/xsr_if.sv
// Handshake interfaces for command words and result words.
interface xsr_in_if;
	logic                     valid;
	logic                     ready;
	logic                     op;
	logic [xsr_pkg::IDX_W-1:0] word_index;
	xsr_pkg::word_t           word_value;

	modport source (output valid, output op, output word_index, output word_value, input ready);
	modport sink (input valid, input op, input word_index, input word_value, output ready);
endinterface

interface xsr_out_if;
	logic           valid;
	logic           ready;
	xsr_pkg::word_t random_value;

	modport source (output valid, output random_value, input ready);
	modport sink (input valid, input random_value, output ready);
endinterface

### hdl/xsr_advance.sv
// One xor/shift/rotate state step for the 256-bit and 512-bit forms.
module xsr_advance (
	input  xsr_pkg::state_t cur,
	input  logic            wide,
	output xsr_pkg::state_t nxt
);
	import xsr_pkg::*;

	always_comb begin
		state_t w;
		word_t  t;
		w = cur;
		if (wide) begin
			t    = w[1] << SHL512;
			w[2] = w[2] ^ w[0];
			w[5] = w[5] ^ w[1];
			w[1] = w[1] ^ w[2];
			w[7] = w[7] ^ w[3];
			w[3] = w[3] ^ w[4];
			w[4] = w[4] ^ w[5];
			w[0] = w[0] ^ w[6];
			w[6] = w[6] ^ w[7];
			w[6] = w[6] ^ t;
			w[7] = rotl(w[7], ROT512);
		end else begin
			t    = w[1] << SHL256;
			w[2] = w[2] ^ w[0];
			w[3] = w[3] ^ w[1];
			w[1] = w[1] ^ w[2];
			w[0] = w[0] ^ w[3];
			w[2] = w[2] ^ t;
			w[3] = rotl(w[3], ROT256);
		end
		nxt = w;
	end

endmodule

### hdl/xor_shift_rotate_prng_unit.sv
// Top level of the xor/shift/rotate generator: command register, scrambler, result register.
// A generate word passes from the command register to the result register before it shows on rsp.
// One word per cycle while rsp keeps up; state step and scrambler both close in the command stage.
// cmd stalls only while a generate word waits behind a result word that rsp has not taken.
// A load word updates the state from the command register and gives no result.
// Reset clears all eight state words, empties both stages and sets the variant to 256 starstar.
module xor_shift_rotate_prng_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	xsr_in_if.sink                      cmd,
	xsr_out_if.source                   rsp,
	input  logic                        cfg_wr_en,
	input  logic [xsr_pkg::VAR_W-1:0]   cfg_wr_data
);
	import xsr_pkg::*;

	logic [VAR_W-1:0] variant_q;
	state_t           state_q;
	state_t           state_nxt;

	logic             vld_s1;
	logic             op_s1;
	logic [IDX_W-1:0] idx_s1;
	word_t            val_s1;

	logic             res_vld_q;
	word_t            res_q;

	logic [VAR_W-1:0] var_sat;
	logic             wide;
	scr_t             scr;
	word_t            sum_d;
	word_t            rot_d;
	word_t            res_d;

	logic out_ok, s1_go, s1_free, gen_go;

	assign var_sat = (variant_q > VAR_MAX) ? VAR_MAX : variant_q;
	assign wide    = (var_sat >= VAR_WIDE_BASE);
	assign scr     = wide ? scr_t'(var_sat - VAR_WIDE_BASE) : scr_t'(var_sat);

	assign out_ok  = !res_vld_q || rsp.ready;
	assign s1_go   = vld_s1 && ((op_s1 == OP_LOAD) || out_ok);
	assign s1_free = !vld_s1 || s1_go;
	assign gen_go  = s1_go && (op_s1 == OP_GEN);

	assign cmd.ready        = s1_free;
	assign rsp.valid        = res_vld_q;
	assign rsp.random_value = res_q;

	xsr_advance u_adv (
		.cur  (state_q),
		.wide (wide),
		.nxt  (state_nxt)
	);

	// scrambler on the state before the step
	always_comb begin
		unique case (scr)
			SCR_SS: begin
				sum_d = (state_q[1] << 2) + state_q[1];
				rot_d = rotl(sum_d, SS_ROT);
				res_d = rot_d + (rot_d << 3);
			end
			SCR_PP: begin
				sum_d = state_q[0] + (wide ? state_q[2] : state_q[3]);
				rot_d = wide ? rotl(sum_d, PP512) : rotl(sum_d, PP256);
				res_d = rot_d + (wide ? state_q[2] : state_q[0]);
			end
			default: begin
				sum_d = state_q[0] + (wide ? state_q[2] : state_q[3]);
				rot_d = sum_d;
				res_d = sum_d;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			variant_q <= VAR_RST;
		end else if (cfg_wr_en) begin
			variant_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (s1_go) begin
			if (op_s1 == OP_LOAD) begin
				state_q[idx_s1] <= val_s1;
			end else begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s1_free) begin
			vld_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && cmd.valid) begin
			op_s1  <= cmd.op;
			idx_s1 <= cmd.word_index;
			val_s1 <= cmd.word_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (gen_go) begin
			res_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (gen_go) begin
			res_q <= res_d;
		end
	end

endmodule

### hdl/xsr_check.sv
// Port-level checks for the generator, bound to the top level.
module xsr_check (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        cmd_valid,
	input logic                        cmd_ready,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input xsr_pkg::word_t              rsp_random_value
);

	// stalled result word holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_random_value))
		else $error("result word changed while stalled");

	// command side only backs up when the result side is stalled
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd_ready |-> rsp_valid && !rsp_ready)
		else $error("command stalled while result side free");

	// an offered result word is fully defined
	a_rsp_known: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !$isunknown(rsp_random_value))
		else $error("result word has unknown bits");

endmodule

bind xor_shift_rotate_prng_unit xsr_check u_xsr_check (
	.clk              (clk),
	.arst_n           (arst_n),
	.cmd_valid        (cmd.valid),
	.cmd_ready        (cmd.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_random_value (rsp.random_value)
);

### bench/tb_xor_shift_rotate_prng_unit.sv
// Self-checking bench for the xor/shift/rotate generator: seed loads, generate words, all variants.
`timescale 1ns / 1ps

module tb_xor_shift_rotate_prng_unit;
	import xsr_pkg::*;

	localparam logic [VAR_W-1:0] V256_PLUS = 3'd0;
	localparam logic [VAR_W-1:0] V256_PP   = 3'd1;
	localparam logic [VAR_W-1:0] V256_SS   = 3'd2;
	localparam logic [VAR_W-1:0] V512_PLUS = 3'd3;
	localparam logic [VAR_W-1:0] V512_PP   = 3'd4;
	localparam logic [VAR_W-1:0] V512_SS   = 3'd5;
	localparam logic [VAR_W-1:0] V_SPARE6  = 3'd6;
	localparam logic [VAR_W-1:0] V_SPARE7  = 3'd7;
	localparam int DRAIN_CYCLES = 6;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [VAR_W-1:0] cfg_wr_data;

	xsr_in_if  cmd_if ();
	xsr_out_if rsp_if ();

	xor_shift_rotate_prng_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd_if),
		.rsp        (rsp_if),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	// generator shadow
	word_t            seed_words [NUM_WORDS];
	logic [VAR_W-1:0] cur_variant;
	word_t            random_q [$];

	int  err_cnt;
	int  gen_cnt;
	int  load_cnt;
	int  cfg_cnt;
	int  checked_cnt;
	bit  send_idle;
	bit  recv_idle;
	int  hold_cycles;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic word_t rol(input word_t x, input int unsigned k);
		logic [2*WORD_W-1:0] d;
		d = {x, x} << k;
		return d[2*WORD_W-1:WORD_W];
	endfunction

	function automatic word_t next_random();
		logic [VAR_W-1:0] v;
		logic             wide;
		scr_t             scr;
		word_t            r;
		word_t            t;
		v    = (cur_variant > VAR_MAX) ? VAR_MAX : cur_variant;
		wide = (v >= VAR_WIDE_BASE);
		scr  = wide ? scr_t'(v - VAR_WIDE_BASE) : scr_t'(v);
		if (scr == SCR_SS) begin
			r = rol(seed_words[1] * 64'd5, SS_ROT) * 64'd9;
		end else if (!wide) begin
			r = seed_words[0] + seed_words[3];
			if (scr == SCR_PP)
				r = rol(r, PP256) + seed_words[0];
		end else begin
			r = seed_words[0] + seed_words[2];
			if (scr == SCR_PP)
				r = rol(r, PP512) + seed_words[2];
		end
		if (wide) begin
			t = seed_words[1] << SHL512;
			seed_words[2] ^= seed_words[0];
			seed_words[5] ^= seed_words[1];
			seed_words[1] ^= seed_words[2];
			seed_words[7] ^= seed_words[3];
			seed_words[3] ^= seed_words[4];
			seed_words[4] ^= seed_words[5];
			seed_words[0] ^= seed_words[6];
			seed_words[6] ^= seed_words[7];
			seed_words[6] ^= t;
			seed_words[7] = rol(seed_words[7], ROT512);
		end else begin
			t = seed_words[1] << SHL256;
			seed_words[2] ^= seed_words[0];
			seed_words[3] ^= seed_words[1];
			seed_words[1] ^= seed_words[2];
			seed_words[0] ^= seed_words[3];
			seed_words[2] ^= t;
			seed_words[3] = rol(seed_words[3], ROT256);
		end
		return r;
	endfunction

	task automatic report(input string what, input word_t got, input word_t want);
		err_cnt++;
		if (err_cnt <= 30)
			$display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
	endtask

	// shadow update and result check, sampled at the rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (seed_words[i])
				seed_words[i] = '0;
			cur_variant = VAR_RST;
			random_q.delete();
		end else begin
			if (cfg_wr_en)
				cur_variant = cfg_wr_data;
			if (cmd_if.valid && cmd_if.ready) begin
				if (cmd_if.op == OP_LOAD)
					seed_words[cmd_if.word_index] = cmd_if.word_value;
				else
					random_q.push_back(next_random());
			end
			if (rsp_if.valid && rsp_if.ready) begin
				checked_cnt++;
				if (random_q.size() == 0)
					report("unexpected random_value", rsp_if.random_value, '0);
				else if (rsp_if.random_value !== random_q[0]) begin
					report("random_value", rsp_if.random_value, random_q[0]);
					void'(random_q.pop_front());
				end else
					void'(random_q.pop_front());
			end
		end
	end

	// result side: random stalls plus a counted long hold-off
	initial begin
		rsp_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				rsp_if.ready = 1'b0;
				hold_cycles--;
			end else if (recv_idle)
				rsp_if.ready = ($urandom_range(99) >= 24);
			else
				rsp_if.ready = 1'b1;
		end
	end

	task automatic send_word(input logic op, input logic [IDX_W-1:0] idx, input word_t val);
		while (send_idle && $urandom_range(99) < 24) begin
			cmd_if.valid = 1'b0;
			@(negedge clk);
		end
		cmd_if.valid      = 1'b1;
		cmd_if.op         = op;
		cmd_if.word_index = idx;
		cmd_if.word_value = val;
		do
			@(posedge clk);
		while (!cmd_if.ready);
		if (op == OP_LOAD)
			load_cnt++;
		else
			gen_cnt++;
		@(negedge clk);
		cmd_if.valid = 1'b0;
	endtask

	task automatic wait_drained();
		while (random_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_variant(input logic [VAR_W-1:0] v);
		wait_drained();
		cfg_wr_en   = 1'b1;
		cfg_wr_data = v;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		cfg_cnt++;
	endtask

	function automatic word_t rand_word();
		return {$urandom, $urandom};
	endfunction

	task automatic gen_word();
		send_word(OP_GEN, IDX_W'($urandom_range(NUM_WORDS - 1)), rand_word());
	endtask

	task automatic test_zero_state();
		gen_word();
	endtask

	task automatic test_seed_extremes();
		send_word(OP_LOAD, 3'd0, '1);
		send_word(OP_LOAD, 3'd1, 64'h8000_0000_0000_0000);
		send_word(OP_LOAD, 3'd2, 64'h1);
		send_word(OP_LOAD, 3'd3, 64'h5555_5555_5555_5555);
		send_word(OP_LOAD, 3'd4, 64'hAAAA_AAAA_AAAA_AAAA);
		send_word(OP_LOAD, 3'd5, '0);
		send_word(OP_LOAD, 3'd6, rand_word());
		send_word(OP_LOAD, 3'd7, '1);
		send_word(OP_GEN, '1, '1);
		send_word(OP_GEN, '0, '0);
	endtask

	task automatic test_variant_extremes();
		set_variant(V256_PLUS);
		gen_word();
		set_variant(V512_SS);
		gen_word();
		set_variant(V_SPARE6);
		gen_word();
		set_variant(V_SPARE7);
		gen_word();
		set_variant(V512_PLUS);
		gen_word();
	endtask

	task automatic random_load();
		int    pick;
		word_t val;
		pick = $urandom_range(99);
		if (pick < 5)
			val = '0;
		else if (pick < 15)
			val = '1;
		else if (pick < 25)
			val = word_t'(1) << $urandom_range(WORD_W - 1);
		else
			val = rand_word();
		send_word(OP_LOAD, IDX_W'($urandom_range(NUM_WORDS - 1)), val);
	endtask

	task automatic test_random_traffic();
		logic [VAR_W-1:0] order [8];
		order = '{V256_PLUS, V256_PP, V256_SS, V512_PLUS, V512_PP, V512_SS, V_SPARE6, V_SPARE7};
		for (int ph = 0; ph < 12; ph++) begin
			send_idle = (ph != 1);
			recv_idle = (ph != 1);
			set_variant(ph < 8 ? order[ph] : VAR_W'($urandom_range(7)));
			// fresh seed for this phase, then mostly generates
			for (int i = 0; i < NUM_WORDS; i++)
				send_word(OP_LOAD, IDX_W'(i), rand_word());
			for (int i = 0; i < 52; i++) begin
				if ($urandom_range(99) < 25)
					random_load();
				else
					gen_word();
			end
		end
		send_idle = 1'b1;
		recv_idle = 1'b1;
	endtask

	task automatic test_backpressure();
		set_variant(V512_PP);
		send_idle   = 1'b0;
		hold_cycles = 150;
		repeat (60) gen_word();
		send_idle = 1'b1;
	endtask

	initial begin
		arst_n            = 1'b0;
		cfg_wr_en         = 1'b0;
		cfg_wr_data       = '0;
		cmd_if.valid      = 1'b0;
		cmd_if.op         = OP_LOAD;
		cmd_if.word_index = '0;
		cmd_if.word_value = '0;
		err_cnt     = 0;
		gen_cnt     = 0;
		load_cnt    = 0;
		cfg_cnt     = 0;
		checked_cnt = 0;
		hold_cycles = 0;
		send_idle   = 1'b1;
		recv_idle   = 1'b1;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_zero_state();
		test_seed_extremes();
		test_variant_extremes();
		test_random_traffic();
		test_backpressure();

		wait_drained();
		repeat (10) @(negedge clk);
		$display("sent %0d generate and %0d load words across %0d variant writes",
			gen_cnt, load_cnt, cfg_cnt);
		$display("checked %0d results, including a long output stall", checked_cnt);
		if (err_cnt == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

### filelist.f
hdl/xsr_pkg.sv
hdl/xsr_if.sv
hdl/xsr_advance.sv
hdl/xor_shift_rotate_prng_unit.sv
hdl/xsr_check.sv
bench/tb_xor_shift_rotate_prng_unit.sv
